/* rtl/pdrs_pkg.sv */
package pdrs_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_TEST,
		ST_RD_TAKE,
		ST_TAKE,
		ST_RD_CLOSE,
		ST_CLOSE,
		ST_RD_DROP,
		ST_DROP,
		ST_DONE
	} state_t;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic CFG_NUM_REQUESTS = 1'b0;
	localparam logic CFG_CAPACITY     = 1'b1;

	localparam int COST_BITS = 24;

endpackage

/* rtl/pdrs_dist_mem.sv */
module pdrs_dist_mem #(
	parameter int PB = 5,
	parameter int DEPTH = 17,
	parameter int DB = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [PB-1:0]     wr_row,
	input  logic [PB-1:0]     wr_col,
	input  logic [DB-1:0]     wr_data,
	input  logic [PB-1:0]     rd_row,
	input  logic [PB-1:0]     rd_col,
	output logic [DB-1:0]     rd_data
);

	localparam int AB = $clog2(DEPTH * DEPTH);

	logic [DB-1:0] mem [DEPTH*DEPTH];
	logic [AB-1:0] wa;
	logic [AB-1:0] ra;

	assign wa = AB'(wr_row * DEPTH + wr_col);
	assign ra = AB'(rd_row * DEPTH + rd_col);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wr_data;
		end
		rd_data <= mem[ra];
	end

endmodule

/* rtl/pickup_delivery_route_search.sv */
// Channel  | Signals                                  | Dir
// item     | start, busy, command, row, col, distance | in
// result   | done, best_cost, found                   | out
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// A distance write leaves busy low, so writes stream every cycle while no search runs.
// A start holds busy high for the search: each candidate is tested in TEST, and each
// take, tour close and drop has a read state before its own state (one distance memory read each).
// The result appears on done for one cycle; it cannot be stalled.
// Reset initialises control state and sets min_edge to all ones; the distance memory is not cleared.
module pickup_delivery_route_search #(
	parameter int MAX_REQUESTS = 8,
	parameter int DIST_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [4:0]  row,
	input  logic [4:0]  col,
	input  logic [15:0] distance,
	output logic        done,
	output logic [23:0] best_cost,
	output logic        found,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int NP = 2 * MAX_REQUESTS + 1;
	localparam int PB = $clog2(NP + 1);
	localparam int CB = pdrs_pkg::COST_BITS;
	localparam int WB = CB + DIST_BITS + 2;
	localparam int RB = $clog2(MAX_REQUESTS + 1);
	localparam int MB = DIST_BITS + PB;

	pdrs_pkg::state_t state_q, state_d;

	logic [3:0] nreq_q, cap_q;
	logic [DIST_BITS-1:0] min_edge_q;
	logic [PB-1:0] path_q [NP];
	logic [PB:0] cand_q [NP+1];
	logic [NP-1:0] vis_q;
	logic [4:0] load_q;
	logic [WB-1:0] part_q, best_q;
	logic hit_q;
	logic [PB-1:0] k_q, v_q, tot_q, n_q;
	logic [DIST_BITS-1:0] rd_data;
	logic [PB-1:0] rd_row, rd_col;
	logic [DIST_BITS-1:0] wdist;
	logic wr_ok, acc, legal, cand_end, bound_ok;
	logic [PB:0] cur_cand;
	logic [PB-1:0] cv;
	logic [RB-1:0] n_clip;
	logic [MB-1:0] rem_cost;
	logic [WB-1:0] bound, tour, take_sum;

	assign busy = (state_q != pdrs_pkg::ST_IDLE);
	assign cfg_ready = ~busy;
	assign acc = start & ~busy;
	assign wdist = DIST_BITS'(distance);
	assign wr_ok = acc && command == pdrs_pkg::CMD_WRITE
		&& row < 5'(NP) && col < 5'(NP);

	assign cur_cand = cand_q[k_q];
	assign cv = cur_cand[PB-1:0];
	assign cand_end = cur_cand > (PB+1)'(tot_q);
	assign legal = !vis_q[cv] && ((cv > n_q) ? vis_q[cv - n_q]
		: ({1'b0, load_q} + 6'd1 <= {2'b0, cap_q}));
	assign tour = part_q + WB'(rd_data);
	assign take_sum = part_q + WB'(rd_data);
	// edges still to go after placing point k
	assign rem_cost = MB'(min_edge_q) * MB'(tot_q + 1'b1 - k_q);
	assign bound = take_sum + WB'(rem_cost);
	assign bound_ok = bound < best_q;
	assign n_clip = (nreq_q > 4'(MAX_REQUESTS)) ? RB'(MAX_REQUESTS) : RB'(nreq_q);

	always_comb begin
		rd_row = path_q[k_q - 1'b1];
		rd_col = v_q;
		unique case (state_q)
			pdrs_pkg::ST_RD_CLOSE: begin
				rd_row = v_q;
				rd_col = '0;
			end
			pdrs_pkg::ST_RD_DROP: rd_col = path_q[k_q];
			default: ;
		endcase
	end

	pdrs_dist_mem #(.PB(PB), .DEPTH(NP), .DB(DIST_BITS)) u_mem (
		.clk(clk), .we(wr_ok), .wr_row(PB'(row)), .wr_col(PB'(col)),
		.wr_data(wdist), .rd_row(rd_row), .rd_col(rd_col), .rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pdrs_pkg::ST_IDLE:
				if (acc && command == pdrs_pkg::CMD_START) state_d = pdrs_pkg::ST_INIT;
			pdrs_pkg::ST_INIT: state_d = (n_clip == '0) ? pdrs_pkg::ST_DONE : pdrs_pkg::ST_TEST;
			pdrs_pkg::ST_TEST:
				if (cand_end) begin
					state_d = (k_q == PB'(1)) ? pdrs_pkg::ST_DONE : pdrs_pkg::ST_RD_DROP;
				end else if (legal) begin
					state_d = pdrs_pkg::ST_RD_TAKE;
				end
			pdrs_pkg::ST_RD_TAKE: state_d = pdrs_pkg::ST_TAKE;
			pdrs_pkg::ST_TAKE:
				if (k_q == tot_q) state_d = pdrs_pkg::ST_RD_CLOSE;
				else if (bound_ok) state_d = pdrs_pkg::ST_TEST;
				else state_d = pdrs_pkg::ST_RD_DROP;
			pdrs_pkg::ST_RD_CLOSE: state_d = pdrs_pkg::ST_CLOSE;
			pdrs_pkg::ST_CLOSE: state_d = pdrs_pkg::ST_RD_DROP;
			pdrs_pkg::ST_RD_DROP: state_d = pdrs_pkg::ST_DROP;
			pdrs_pkg::ST_DROP: state_d = pdrs_pkg::ST_TEST;
			pdrs_pkg::ST_DONE: state_d = pdrs_pkg::ST_IDLE;
			default: state_d = pdrs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == pdrs_pkg::ST_DONE);
		found = hit_q;
		best_cost = (!hit_q) ? '0 : (best_q > WB'(24'hFFFFFF)) ? 24'hFFFFFF : best_q[CB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdrs_pkg::ST_IDLE;
			nreq_q <= 4'd1;
			cap_q <= 4'd1;
			min_edge_q <= '1;
			hit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pdrs_pkg::CFG_NUM_REQUESTS) nreq_q <= cfg_data;
				else nreq_q <= nreq_q;
				if (cfg_index == pdrs_pkg::CFG_CAPACITY) cap_q <= cfg_data;
			end
			if (wr_ok && wdist != '0 && wdist < min_edge_q) min_edge_q <= wdist;
			if (state_q == pdrs_pkg::ST_INIT) hit_q <= 1'b0;
			if (state_q == pdrs_pkg::ST_CLOSE && tour < best_q) hit_q <= 1'b1;
		end
	end

	// datapath of the search; path, candidates and sums need no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			pdrs_pkg::ST_INIT: begin
				n_q <= PB'(n_clip);
				tot_q <= PB'({n_clip, 1'b0});
				k_q <= PB'(1);
				cand_q[1] <= (PB+1)'(1);
				path_q[0] <= '0;
				vis_q <= '0;
				load_q <= '0;
				part_q <= '0;
				best_q <= '1;
			end
			pdrs_pkg::ST_TEST:
				if (cand_end) begin
					k_q <= k_q - 1'b1;
				end else begin
					v_q <= cv;
					cand_q[k_q] <= cur_cand + 1'b1;
				end
			pdrs_pkg::ST_TAKE: begin
				// advance into the point; the bound test uses the new sum
				path_q[k_q] <= v_q;
				vis_q[v_q] <= 1'b1;
				load_q <= (v_q <= n_q) ? load_q + 1'b1 : load_q - 1'b1;
				part_q <= take_sum;
				if (k_q != tot_q && bound_ok) begin
					k_q <= k_q + 1'b1;
					cand_q[k_q + 1'b1] <= (PB+1)'(1);
				end
			end
			pdrs_pkg::ST_RD_CLOSE: ;
			pdrs_pkg::ST_CLOSE:
				if (tour < best_q) best_q <= tour;
			pdrs_pkg::ST_DROP: begin
				load_q <= (path_q[k_q] <= n_q) ? load_q - 1'b1 : load_q + 1'b1;
				vis_q[path_q[k_q]] <= 1'b0;
				part_q <= part_q - WB'(rd_data);
			end
			default: ;
		endcase
	end

	ap_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done without busy");
	ap_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	ap_found_cost: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> best_cost == '0) else $error("cost without tour");

endmodule

/* verif/pdrs_checker.sv */
`timescale 1ns / 1ps

module pdrs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        command,
	input  logic [4:0]  row,
	input  logic [4:0]  col,
	input  logic [15:0] distance,
	input  logic        done,
	input  logic [23:0] best_cost,
	input  logic        found,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	output int          fail_count,
	output int          pending
);

	localparam int NPTS = 17;

	typedef struct packed {
		logic [23:0] cost;
		logic        hit;
	} tour_t;

	tour_t       tour_q[$];
	logic [15:0] dist_mem[NPTS][NPTS];
	logic [15:0] min_edge;
	logic [3:0]  pairs_reg;
	logic [3:0]  cap_reg;

	// search state shared by the predictor and its backtrack helper
	int unsigned      path[NPTS];
	logic [NPTS-1:0]  seen;
	int               load;
	longint unsigned  part;

	function automatic void back_out(int unsigned k, int unsigned n);
		int unsigned v;
		v = path[k];
		if (v <= n)
			load--;
		else
			load++;
		part -= dist_mem[path[k-1]][v];
		seen[v] = 1'b0;
	endfunction

	function automatic tour_t shortest_tour();
		int unsigned     n, total, k, v;
		int unsigned     next_pt[NPTS+1];
		longint unsigned best, tour;
		logic            hit;
		tour_t           res;
		n = pairs_reg;
		if (n > 8)
			n = 8;
		best = '1;
		part = 0;
		load = 0;
		seen = '0;
		hit = 1'b0;
		foreach (path[i])
			path[i] = 0;
		if (n != 0) begin
			total = 2 * n;
			k = 1;
			next_pt[1] = 1;
			while (k >= 1) begin
				if (next_pt[k] > total) begin
					k--;
					if (k == 0)
						break;
					back_out(k, n);
					continue;
				end
				v = next_pt[k];
				next_pt[k]++;
				if (seen[v])
					continue;
				if (v > n ? !seen[v-n] : (load + 1 > int'(cap_reg)))
					continue;
				path[k] = v;
				part += dist_mem[path[k-1]][v];
				seen[v] = 1'b1;
				if (v <= n)
					load++;
				else
					load--;
				if (k == total) begin
					tour = part + dist_mem[v][0];
					if (tour < best) begin
						best = tour;
						hit = 1'b1;
					end
					back_out(k, n);
				end else if (part + longint'(min_edge) * (total + 1 - k) < best) begin
					k++;
					next_pt[k] = 1;
				end else begin
					back_out(k, n);
				end
			end
		end
		res.hit = hit;
		res.cost = !hit ? 24'd0 : (best > 64'hFFFFFF ? 24'hFFFFFF : best[23:0]);
		return res;
	endfunction

	assign pending = tour_q.size();

	always @(posedge clk or negedge arst_n) begin
		tour_t want;
		if (!arst_n) begin
			tour_q.delete();
			min_edge <= 16'hFFFF;
			pairs_reg <= 4'd1;
			cap_reg <= 4'd1;
			fail_count <= 0;
		end else begin
			if (done) begin
				if (tour_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result beat: cost %0d found %0b", best_cost, found);
				end else begin
					want = tour_q.pop_front();
					if (want.cost !== best_cost || want.hit !== found) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("result mismatch: expected cost %0d found %0b, got cost %0d found %0b",
								want.cost, want.hit, best_cost, found);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == pdrs_pkg::CFG_NUM_REQUESTS)
					pairs_reg <= cfg_data;
				else
					cap_reg <= cfg_data;
			end
			if (start && !busy) begin
				if (command == pdrs_pkg::CMD_START) begin
					tour_q.push_back(shortest_tour());
				end else if (row < NPTS && col < NPTS) begin
					dist_mem[row][col] = distance;
					if (distance != 0 && distance < min_edge)
						min_edge <= distance;
				end
			end
		end
	end

endmodule

/* verif/pickup_delivery_route_search_tb.sv */
`timescale 1ns / 1ps

module pickup_delivery_route_search_tb;

	localparam int LIMIT = 4000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        command = pdrs_pkg::CMD_WRITE;
	logic [4:0]  row = '0;
	logic [4:0]  col = '0;
	logic [15:0] distance = '0;
	logic        done;
	logic [23:0] best_cost;
	logic        found;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = pdrs_pkg::CFG_NUM_REQUESTS;
	logic [3:0]  cfg_data = '0;
	int          fail_count;
	int          pending;
	int          idle_pct = 0;
	int          cycles = 0;

	always #10 clk = ~clk;

	pickup_delivery_route_search dut (.*);

	pdrs_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// call at a falling edge; returns at a falling edge
	task automatic send(input logic cmd, input logic [4:0] r, input logic [4:0] c,
			input logic [15:0] d);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		command = cmd;
		row = r;
		col = c;
		distance = d;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic run_search();
		send(pdrs_pkg::CMD_START, 5'($urandom), 5'($urandom), 16'($urandom));
	endtask

	task automatic settle();
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [3:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic setup(input logic [3:0] pairs, input logic [3:0] cap);
		settle();
		set_reg(pdrs_pkg::CFG_NUM_REQUESTS, pairs);
		set_reg(pdrs_pkg::CFG_CAPACITY, cap);
	endtask

	initial begin
		int n, span;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// clear every entry so no search ever reads an unwritten one
		for (int r = 0; r < 17; r++)
			for (int c = 0; c < 17; c++)
				send(pdrs_pkg::CMD_WRITE, 5'(r), 5'(c), 16'd0);
		run_search();
		setup(4'd8, 4'd8);
		run_search();
		setup(4'd15, 4'd3);
		run_search();
		setup(4'd8, 4'd0);
		run_search();
		setup(4'd0, 4'd2);
		run_search();
		// out of range point must leave min_edge alone
		send(pdrs_pkg::CMD_WRITE, 5'd31, 5'd5, 16'd1);
		send(pdrs_pkg::CMD_WRITE, 5'd3, 5'd17, 16'd1);
		setup(4'd1, 4'd1);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				send(pdrs_pkg::CMD_WRITE, 5'(r), 5'(c), 16'hFFFF);
		run_search();
		setup(4'd2, 4'd1);
		send(pdrs_pkg::CMD_WRITE, 5'd1, 5'd3, 16'd1);
		run_search();
		setup(4'd2, 4'd2);
		run_search();

		for (int g = 0; g < 30; g++) begin
			idle_pct = (g % 3 == 0) ? 0 : (g % 3 == 1) ? 88 : 13;
			n = ($urandom_range(5) == 0) ? $urandom_range(4) : $urandom_range(1, 3);
			setup(4'(n), 4'($urandom_range(7) == 0 ? $urandom_range(15) : $urandom_range(3)));
			span = 2 * n;
			for (int i = 0; i < 12; i++) begin
				case ($urandom_range(9))
					0: run_search();
					1: send(pdrs_pkg::CMD_WRITE, 5'($urandom), 5'($urandom), 16'($urandom));
					2: send(pdrs_pkg::CMD_WRITE, 5'($urandom_range(span)),
						5'($urandom_range(span)), $urandom_range(1) ? 16'hFFFF : 16'd0);
					default: send(pdrs_pkg::CMD_WRITE, 5'($urandom_range(span)),
						5'($urandom_range(span)),
						16'($urandom_range(1) ? $urandom : $urandom_range(200)));
				endcase
			end
			run_search();
			if (g == 20)
				settle();
		end

		settle();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
